// ----- src/hwdp_pkg.sv -----
// shared types, constants and helpers for the half weight dot product
`timescale 1ns / 1ps
`default_nettype none

package hwdp_pkg;

    // canonical quiet nan and binary32 field limits
    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [30:0] INF_MAG  = 31'h7F80_0000;
    localparam logic [7:0]  EXP_ONES = 8'hFF;

    // control that travels along with each word through the pipeline
    typedef struct packed {
        logic valid;
        logic last;
    } tag_t;

    // binary32 nan test
    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == EXP_ONES) && (b[22:0] != 23'd0);
    endfunction

    // binary32 infinity test
    function automatic logic is_inf(input logic [31:0] b);
        return (b[30:23] == EXP_ONES) && (b[22:0] == 23'd0);
    endfunction

endpackage

`default_nettype wire

// ----- src/hwdp_fmul.sv -----
// widen the half weight and multiply it by the activation, three stages
`timescale 1ns / 1ps
`default_nettype none

module hwdp_fmul import hwdp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire tag_t        tag_in,
    input  wire logic [15:0] weight_half,
    input  wire logic [31:0] activation,
    output tag_t             tag_out,
    output logic [31:0]      product
);

    // exact half to single widening, subnormals normalized
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic       s;
        logic [4:0] ex;
        logic [9:0] man;
        logic [7:0] e32;
        logic [9:0] m;
        logic [31:0] r;
        s   = h[15];
        ex  = h[14:10];
        man = h[9:0];
        e32 = 8'd0;
        m   = 10'd0;
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                r = {s, 31'd0};
            end else begin
                for (int i = 0; i < 10; i++) begin
                    if (man[i]) begin
                        e32 = 8'(103 + i);
                        m   = 10'(man << (10 - i));
                    end
                end
                r = {s, e32, m, 13'd0};
            end
        end else if (ex == 5'h1F) begin
            r = {s, EXP_ONES, man, 13'd0};
        end else begin
            r = {s, 8'({3'd0, ex} + 8'd112), man, 13'd0};
        end
        return r;
    endfunction

    // stage a: unpack and classify
    tag_t               a_tag_reg;
    logic               a_sign_reg;
    logic               a_spec_reg;
    logic [31:0]        a_specval_reg;
    logic [23:0]        a_ma_reg;
    logic [23:0]        a_mw_reg;
    logic signed [11:0] a_exp_reg;

    logic [31:0]        wb;
    logic               sgn;
    logic               spec;
    logic [31:0]        specval;
    logic [23:0]        ma;
    logic signed [11:0] ea;

    always_comb begin
        wb      = widen_half(weight_half);
        sgn     = wb[31] ^ activation[31];
        spec    = 1'b1;
        specval = {sgn, 31'd0};
        ma      = {1'b1, activation[22:0]};
        ea      = 12'(signed'({4'd0, activation[30:23]}));
        if (is_nan(wb) || is_nan(activation)) begin
            specval = QNAN;
        end else if (is_inf(wb) || is_inf(activation)) begin
            if (wb[30:0] == 31'd0 || activation[30:0] == 31'd0) begin
                specval = QNAN;
            end else begin
                specval = {sgn, INF_MAG};
            end
        end else if (wb[30:0] == 31'd0 || activation[30:0] == 31'd0) begin
            specval = {sgn, 31'd0};
        end else begin
            spec = 1'b0;
            // subnormal activation: bring the leading one to the hidden bit
            if (activation[30:23] == 8'd0) begin
                for (int i = 0; i < 23; i++) begin
                    if (activation[i]) begin
                        ma = 24'({1'b0, activation[22:0]} << (23 - i));
                        ea = 12'(i - 22);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_tag_reg <= '0;
        end else if (en) begin
            a_tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_sign_reg    <= sgn;
            a_spec_reg    <= spec;
            a_specval_reg <= specval;
            a_ma_reg      <= ma;
            a_mw_reg      <= {1'b1, wb[22:0]};
            a_exp_reg     <= ea + 12'(signed'({4'd0, wb[30:23]})) - 12'sd127;
        end
    end

    // stage b: significand multiply
    tag_t               b_tag_reg;
    logic               b_sign_reg;
    logic               b_spec_reg;
    logic [31:0]        b_specval_reg;
    logic [47:0]        b_prod_reg;
    logic signed [11:0] b_exp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_tag_reg <= '0;
        end else if (en) begin
            b_tag_reg <= a_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sign_reg    <= a_sign_reg;
            b_spec_reg    <= a_spec_reg;
            b_specval_reg <= a_specval_reg;
            b_prod_reg    <= a_ma_reg * a_mw_reg;
            b_exp_reg     <= a_exp_reg;
        end
    end

    // stage c: normalize, denormalize and round to nearest even
    tag_t        c_tag_reg;
    logic [31:0] c_prod_reg;

    logic [47:0]        pn;
    logic signed [11:0] ex;
    logic [5:0]         sh;
    logic [47:0]        q;
    logic               lost;
    logic [23:0]        mant;
    logic               g;
    logic               st;
    logic [7:0]         ef;
    logic [30:0]        mag;
    logic [31:0]        rounded;

    always_comb begin
        pn   = b_prod_reg;
        ex   = b_exp_reg;
        sh   = 6'd0;
        q    = 48'd0;
        lost = 1'b0;
        mant = 24'd0;
        g    = 1'b0;
        st   = 1'b0;
        ef   = 8'd0;
        mag  = 31'd0;
        if (b_prod_reg[47]) begin
            ex = b_exp_reg + 12'sd1;
        end else begin
            pn = b_prod_reg << 1;
        end
        if (ex >= 12'sd255) begin
            mag = INF_MAG;
        end else begin
            if (ex >= 12'sd1) begin
                mant = pn[47:24];
                g    = pn[23];
                st   = |pn[22:0];
                ef   = ex[7:0];
            end else begin
                sh   = (ex < -12'sd46) ? 6'd48 : 6'(12'sd1 - ex);
                q    = pn >> sh;
                lost = |(pn & ((48'd1 << sh) - 48'd1));
                mant = q[47:24];
                g    = q[23];
                st   = (|q[22:0]) | lost;
            end
            mag = {ef, mant[22:0]} + 31'(g & (st | mant[0]));
        end
        rounded = b_spec_reg ? b_specval_reg : {b_sign_reg, mag};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_tag_reg <= '0;
        end else if (en) begin
            c_tag_reg <= b_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_prod_reg <= rounded;
        end
    end

    assign tag_out = c_tag_reg;
    assign product = c_prod_reg;

endmodule

`default_nettype wire

// ----- src/hwdp_fadd.sv -----
// single precision adder with round to nearest even, purely combinational
`timescale 1ns / 1ps
`default_nettype none

module hwdp_fadd import hwdp_pkg::*; (
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [31:0]      y
);

    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  eb;
    logic [7:0]  es;
    logic [7:0]  d;
    logic [26:0] ax;
    logic [26:0] bx;
    logic [26:0] al;
    logic        lost;
    logic [27:0] s28;
    logic [8:0]  e;
    logic [4:0]  msb;
    logic [8:0]  lz;
    logic [8:0]  shl;
    logic [26:0] nrm;
    logic [7:0]  ef;
    logic [30:0] mag;

    always_comb begin
        big  = a;
        sml  = b;
        eb   = 8'd0;
        es   = 8'd0;
        d    = 8'd0;
        ax   = 27'd0;
        bx   = 27'd0;
        al   = 27'd0;
        lost = 1'b0;
        s28  = 28'd0;
        e    = 9'd0;
        msb  = 5'd0;
        lz   = 9'd0;
        shl  = 9'd0;
        nrm  = 27'd0;
        ef   = 8'd0;
        mag  = 31'd0;
        y    = 32'd0;
        // special operands first
        if (is_nan(a) || is_nan(b)) begin
            y = QNAN;
        end else if (is_inf(a) && is_inf(b) && (a[31] != b[31])) begin
            y = QNAN;
        end else if (is_inf(a)) begin
            y = a;
        end else if (is_inf(b)) begin
            y = b;
        end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
            y = {a[31] & b[31], 31'd0};
        end else begin
            // larger magnitude on the big side
            if (a[30:0] < b[30:0]) begin
                big = b;
                sml = a;
            end
            eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
            es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
            d  = eb - es;
            ax = {big[30:23] != 8'd0, big[22:0], 3'd0};
            bx = {sml[30:23] != 8'd0, sml[22:0], 3'd0};
            // align with guard, round and sticky
            if (d >= 8'd27) begin
                al   = 27'd0;
                lost = |bx;
            end else begin
                al   = bx >> d;
                lost = |(bx & ((27'd1 << d) - 27'd1));
            end
            al[0] = al[0] | lost;
            if (big[31] != sml[31]) begin
                s28 = {1'b0, ax} - {1'b0, al};
            end else begin
                s28 = {1'b0, ax} + {1'b0, al};
            end
            if (s28 == 28'd0) begin
                y = 32'd0;
            end else begin
                e = {1'b0, eb};
                if (s28[27]) begin
                    nrm = {s28[27:2], s28[1] | s28[0]};
                    e   = e + 9'd1;
                end else begin
                    // leading one search, shift limited by the exponent
                    for (int i = 0; i < 27; i++) begin
                        if (s28[i]) begin
                            msb = 5'(i);
                        end
                    end
                    lz  = 9'd26 - {4'd0, msb};
                    shl = (lz < e - 9'd1) ? lz : e - 9'd1;
                    nrm = s28[26:0] << shl;
                    e   = e - shl;
                end
                if (e >= 9'd255) begin
                    mag = INF_MAG;
                end else begin
                    ef  = nrm[26] ? e[7:0] : 8'd0;
                    mag = {ef, nrm[25:3]} + 31'(nrm[2] & (nrm[1] | nrm[0] | nrm[3]));
                end
                y = {big[31], mag};
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/half_weight_dot_product.sv -----
// top level: streaming half weight by single activation dot product
//
// s_ channel: one word per element, weight and activation in s_tdata,
// s_tlast marks the final element of a row. m_ channel: one word per row,
// the binary32 row sum in m_tdata, sent after the word that had s_tlast.
// The row sum passes the input register and the unpack, multiply and round
// stages, and is then held in the output register that drives m_tvalid.
// Throughput: one word per cycle while the pipeline is not stalled; the
// running sum is updated by a combinational adder loop, which sets that rate.
// Products are rounded to nearest even, then added in element order with
// a second rounding; nan results are the quiet nan 0x7FC00000.
// Reset: the pipeline empties, the running sum is positive zero and no
// result is pending.
// Stall: while a row sum waits in the output register and the next row
// end reaches the accumulate stage, the whole pipeline holds and s_tready
// drops; words without s_tlast keep flowing while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module half_weight_dot_product import hwdp_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // weight_half[15:0], activation[47:16]
    input  wire logic        s_tlast,   // last_of_row
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // row_sum[31:0]
);

    tag_t        in_tag_reg;
    logic [15:0] in_w_reg;
    logic [31:0] in_a_reg;
    tag_t        p_tag;
    logic [31:0] p_bits;
    logic [31:0] sum_reg;
    logic [31:0] sum_next;
    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        en;
    logic        row_end;

    // pipeline advances unless a row end would overwrite a waiting result
    assign row_end  = p_tag.valid && p_tag.last;
    assign en       = !(row_end && m_valid_reg && !m_tready);
    assign s_tready = en;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_tag_reg <= '0;
        end else if (en) begin
            in_tag_reg <= '{valid: s_tvalid, last: s_tlast};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_w_reg <= s_tdata[15:0];
            in_a_reg <= s_tdata[47:16];
        end
    end

    // widen and multiply
    hwdp_fmul u_fmul (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .tag_in      (in_tag_reg),
        .weight_half (in_w_reg),
        .activation  (in_a_reg),
        .tag_out     (p_tag),
        .product     (p_bits)
    );

    // accumulate
    hwdp_fadd u_fadd (
        .a (sum_reg),
        .b (p_bits),
        .y (sum_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= 32'd0;
        end else if (en && p_tag.valid) begin
            sum_reg <= p_tag.last ? 32'd0 : sum_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en && row_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && row_end) begin
            m_data_reg <= sum_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // a result only appears after a row end reached the accumulate stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(row_end))
        else $error("row sum without row end");

    // the input only stalls behind a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && row_end))
        else $error("input stalled without cause");

    // the running sum is cleared after each row end
    assert property (@(posedge aclk) disable iff (!aresetn)
        (en && row_end) |=> (sum_reg == 32'd0))
        else $error("running sum not cleared");

    // only the canonical nan is ever held
    assert property (@(posedge aclk) disable iff (!aresetn)
        is_nan(sum_reg) |-> (sum_reg == QNAN))
        else $error("non canonical nan in sum");

endmodule

`default_nettype wire
